FILE: hw/rtl/task_dependency_scheduler_unit_defines.svh
// Assertion macros for the task scheduler checker
`ifndef TASK_DEPENDENCY_SCHEDULER_UNIT_DEFINES_SVH
`define TASK_DEPENDENCY_SCHEDULER_UNIT_DEFINES_SVH
// assert that a implies b at every edge out of reset
`define TDS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// assert that a implies b in the next cycle
`define TDS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

FILE: hw/rtl/tds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tds_pkg
// Status codes and action codes of the task scheduler.
// ---------------------------------------------------------------------------
package tds_pkg;
	localparam logic       ACT_ADD     = 1'b0;
	localparam logic       ACT_NEXT    = 1'b1;
	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_GRANTED  = 3'd2;
	localparam logic [2:0] ST_REQUEUED = 3'd3;
	localparam logic [2:0] ST_DONE     = 3'd4;
	localparam logic [2:0] ST_ALL_DONE = 3'd5;
	localparam logic [2:0] ST_WAITING  = 3'd6;
endpackage

FILE: hw/rtl/tds_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tds_req_if
// Request channel: add or next item.
// ---------------------------------------------------------------------------
interface tds_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [3:0]  task_id;
	logic [2:0]  set_count;
	logic [15:0] dep_set_0;
	logic [15:0] dep_set_1;
	logic [15:0] dep_set_2;
	logic [15:0] dep_set_3;
	logic [15:0] pick;
	modport source (output valid, action, task_id, set_count, dep_set_0, dep_set_1,
		dep_set_2, dep_set_3, pick, input ready);
	modport sink (input valid, action, task_id, set_count, dep_set_0, dep_set_1,
		dep_set_2, dep_set_3, pick, output ready);
endinterface

FILE: hw/rtl/tds_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tds_rsp_if
// Response channel: one result item per request.
// ---------------------------------------------------------------------------
interface tds_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] granted_id;
	logic [4:0] ready_length;
	modport source (output valid, status, granted_id, ready_length, input ready);
	modport sink (input valid, status, granted_id, ready_length, output ready);
endinterface

FILE: hw/rtl/tds_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tds_cell
// One ready-list slot. Loads, shifts in from its right neighbour, or holds.
// ---------------------------------------------------------------------------
module tds_cell #(
	parameter int IdW = 4
) (
	input  logic           clk,
	input  logic           load,
	input  logic [IdW-1:0] load_id,
	input  logic           shift,
	input  logic [IdW-1:0] right_id,
	output logic [IdW-1:0] id
);
	logic [IdW-1:0] id_q;

	always_ff @(posedge clk) begin
		if (load) begin
			id_q <= load_id;
		end else if (shift) begin
			id_q <= right_id;
		end
	end

	assign id = id_q;
endmodule

FILE: hw/rtl/task_dependency_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// task_dependency_scheduler_unit
// Task table with dependency sets and a ready list kept in a row of cells.
// ---------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | action, task_id, set_count, dep_set_0..3, pick
// rsp     | out | status, granted_id, ready_length
// One item at a time. Add, or next on an empty list: result the cycle after
// acceptance. Next: modulo of pick by the list length by restoring
// subtraction (MODC), then a pass over the list entries (SHIFT) while the list
// closes up behind the picked entry, a decision state (DECIDE), then RESP.
// Reset clears lengths and masks; ready_list and task table need no clearing.
// A stalled result holds the block until it is taken.
// ---------------------------------------------------------------------------
module task_dependency_scheduler_unit #(
	parameter int MAX_TASKS = 16,
	parameter int MAX_SETS  = 4
) (
	input  logic clk,
	input  logic arst_n,
	tds_req_if.sink   req,
	tds_rsp_if.source rsp
);
	localparam int IdW  = $clog2(MAX_TASKS);
	localparam int LenW = $clog2(MAX_TASKS + 1);
	localparam int TW   = (MAX_TASKS < 16) ? MAX_TASKS : 16;

	typedef enum logic [2:0] {IDLE, MODC, SHIFT, DECIDE, RESP} state_t;
	state_t state_q;

	// task id reduced to the table size
	function automatic logic [IdW-1:0] id_wrap(input logic [3:0] tid);
		id_wrap = '0;
		for (int t = 0; t < 16; t++) begin
			if (tid == 4'(t)) begin
				id_wrap = IdW'(t % MAX_TASKS);
			end
		end
	endfunction

	logic [IdW-1:0]  list_id [MAX_TASKS];
	logic [IdW-1:0]  right_id [MAX_TASKS];
	logic [MAX_TASKS-1:0] load_v, shift_v;
	logic [IdW-1:0]  load_id;
	logic [IdW-1:0]  add_id;

	logic [MAX_SETS-1:0][15:0] dep_q [MAX_TASKS];
	logic [2:0]  cnt_q [MAX_TASKS];
	logic [MAX_TASKS-1:0] reg_q, done_q;
	logic [LenW-1:0] len_q;
	logic [15:0] rem_q;
	logic [15:0] pick_q;
	logic [4:0]  bit_q;
	logic [LenW-1:0] pos_q;
	logic [IdW-1:0]  id_q;
	logic [2:0]  st_q;
	logic [3:0]  gid_q;

	assign add_id = id_wrap(req.task_id);

	genvar g;
	generate
		for (g = 0; g < MAX_TASKS; g++) begin : g_cell
			if (g == MAX_TASKS - 1) begin : g_last
				assign right_id[g] = list_id[g];
			end else begin : g_mid
				assign right_id[g] = list_id[g+1];
			end
			tds_cell #(.IdW(IdW)) u_cell (
				.clk(clk), .load(load_v[g]), .load_id(load_id),
				.shift(shift_v[g]), .right_id(right_id[g]), .id(list_id[g])
			);
		end
	endgenerate

	// dependency masks of the picked task against the done mask, clipped to 16 bits
	logic [MAX_TASKS-1:0] done_ext;
	logic elig;
	logic [2:0] cnt_eff;
	logic [16:0] trial;
	always_comb begin
		elig = 1'b0;
		cnt_eff = cnt_q[id_q];
		for (int s = 0; s < MAX_SETS; s++) begin
			if (3'(s) < cnt_eff) begin
				if ((dep_q[id_q][s] & ~16'(done_ext)) == 16'd0) begin
					elig = 1'b1;
				end
			end
		end
		trial = {rem_q, pick_q[15]} - 17'(len_q);
	end
	always_comb begin
		done_ext = done_q;
		if (MAX_TASKS > 16) begin
			done_ext = '0;
			done_ext[TW-1:0] = done_q[TW-1:0];
		end
	end

	always_comb begin
		load_v = '0;
		shift_v = '0;
		load_id = id_q;
		if (state_q == IDLE && req.valid && req.action == tds_pkg::ACT_ADD
				&& len_q < LenW'(MAX_TASKS)) begin
			load_v[len_q[IdW-1:0]] = 1'b1;
			load_id = add_id;
		end else if (state_q == SHIFT && pos_q >= LenW'(rem_q)
				&& pos_q + 1'b1 < len_q) begin
			shift_v[pos_q[IdW-1:0]] = 1'b1;
		end else if (state_q == DECIDE && !done_q[id_q] && !elig) begin
			load_v[len_q[IdW-1:0]] = 1'b1;
		end
	end

	assign req.ready = (state_q == IDLE);
	assign rsp.valid = (state_q == RESP);
	assign rsp.status = st_q;
	assign rsp.granted_id = gid_q;
	assign rsp.ready_length = 5'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			len_q <= '0;
			reg_q <= '0;
			done_q <= '0;
			st_q <= tds_pkg::ST_ADDED;
			gid_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						gid_q <= '0;
						id_q <= '0;
						if (req.action == tds_pkg::ACT_ADD) begin
							state_q <= RESP;
							if (len_q >= LenW'(MAX_TASKS)) begin
								st_q <= tds_pkg::ST_FULL;
							end else begin
								st_q <= tds_pkg::ST_ADDED;
								len_q <= len_q + 1'b1;
								for (int s = 0; s < MAX_SETS; s++) begin
									dep_q[add_id][s] <= (s == 0) ? req.dep_set_0 :
										(s == 1) ? req.dep_set_1 :
										(s == 2) ? req.dep_set_2 : req.dep_set_3;
								end
								cnt_q[add_id] <= (req.set_count > 3'(MAX_SETS)) ?
									3'(MAX_SETS) : req.set_count;
								if (req.set_count != 3'd0) begin
									reg_q[add_id] <= 1'b1;
								end
							end
						end else if (len_q == '0) begin
							state_q <= RESP;
							st_q <= (done_q == reg_q) ? tds_pkg::ST_ALL_DONE :
								tds_pkg::ST_WAITING;
						end else begin
							state_q <= MODC;
							rem_q <= '0;
							pick_q <= req.pick;
							bit_q <= '0;
						end
					end
				end
				MODC: begin
					if (!trial[16]) begin
						rem_q <= trial[15:0];
					end else begin
						rem_q <= {rem_q[14:0], pick_q[15]};
					end
					pick_q <= {pick_q[14:0], 1'b0};
					bit_q <= bit_q + 1'b1;
					if (bit_q == 5'd15) begin
						state_q <= SHIFT;
					end
				end
				SHIFT: begin
					if (pos_q == LenW'(rem_q)) begin
						id_q <= list_id[pos_q[IdW-1:0]];
					end
					if (pos_q + 1'b1 >= len_q) begin
						state_q <= DECIDE;
						len_q <= len_q - 1'b1;
					end
					pos_q <= pos_q + 1'b1;
				end
				DECIDE: begin
					state_q <= RESP;
					gid_q <= 4'(id_q);
					if (done_q[id_q]) begin
						st_q <= tds_pkg::ST_DONE;
					end else if (!elig) begin
						st_q <= tds_pkg::ST_REQUEUED;
						len_q <= len_q + 1'b1;
					end else begin
						st_q <= tds_pkg::ST_GRANTED;
						done_q[id_q] <= 1'b1;
					end
				end
				RESP: begin
					if (rsp.ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
			if (state_q == MODC && bit_q == 5'd15) begin
				pos_q <= '0;
			end
		end
	end
endmodule

FILE: hw/rtl/tds_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tds_checker
// Port-level checks on the scheduler handshakes and response fields.
// ---------------------------------------------------------------------------
`include "task_dependency_scheduler_unit_defines.svh"
module tds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status,
	input logic [3:0] granted_id,
	input logic [4:0] ready_length
);
	// statuses that carry no task id
	logic no_id;
	assign no_id = (status == tds_pkg::ST_ADDED) || (status == tds_pkg::ST_FULL) ||
		(status == tds_pkg::ST_ALL_DONE) || (status == tds_pkg::ST_WAITING);

	`TDS_ASSERT_IMP(a_one_at_a_time, clk, arst_n, rsp_valid, !req_ready)
	`TDS_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
	`TDS_ASSERT_IMP(a_noid, clk, arst_n, rsp_valid && no_id, granted_id == 4'd0)
	`TDS_ASSERT_IMP(a_len, clk, arst_n, rsp_valid, ready_length <= 5'd16)
endmodule

bind task_dependency_scheduler_unit tds_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
	.granted_id(rsp.granted_id), .ready_length(rsp.ready_length)
);

FILE: sim/tb_task_dependency_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_task_dependency_scheduler_unit
// Drives add and next items into the task scheduler with random idling on
// both channels, predicts every response from a local model of the ready
// list and completion masks, and compares each response as a whole.
// ---------------------------------------------------------------------------
module tb_task_dependency_scheduler_unit;
	localparam int NTASK      = 16;
	localparam int NSET       = 4;
	localparam int CYCLE_CAP  = 400000;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] granted_id;
		logic [4:0] ready_length;
	} sched_rsp_t;

	class sched_scoreboard;
		logic [3:0]  run_list[NTASK];
		int          run_len;
		logic [15:0] deps[NTASK][NSET];
		int          nsets[NTASK];
		logic [15:0] reg_mask;
		logic [15:0] done_mask;
		sched_rsp_t  pending[$];
		int          errors;
		int          checked;
		int          n_grant;
		int          n_full;
		int          n_wait;
		int          n_all;

		function void clear();
			run_len   = 0;
			reg_mask  = '0;
			done_mask = '0;
			errors    = 0;
			checked   = 0;
			n_grant   = 0;
			n_full    = 0;
			n_wait    = 0;
			n_all     = 0;
		endfunction

		function bit can_run(int id);
			for (int s = 0; s < nsets[id]; s++)
				if ((deps[id][s] & ~done_mask) == 16'h0)
					return 1;
			return 0;
		endfunction

		function void note_item(logic act, logic [3:0] tid, logic [2:0] cnt,
				logic [15:0] d0, logic [15:0] d1, logic [15:0] d2, logic [15:0] d3,
				logic [15:0] pk);
			sched_rsp_t r;
			int idx;
			int id;
			r = '0;
			if (act == tds_pkg::ACT_ADD) begin
				if (run_len >= NTASK) begin
					r.status = tds_pkg::ST_FULL;
					n_full++;
				end else begin
					id = tid;
					deps[id][0] = d0;
					deps[id][1] = d1;
					deps[id][2] = d2;
					deps[id][3] = d3;
					nsets[id] = (cnt > NSET) ? NSET : cnt;
					if (nsets[id] > 0)
						reg_mask[id] = 1'b1;
					run_list[run_len] = tid;
					run_len++;
					r.status = tds_pkg::ST_ADDED;
				end
			end else if (run_len == 0) begin
				r.status = (done_mask == reg_mask) ? tds_pkg::ST_ALL_DONE :
					tds_pkg::ST_WAITING;
				if (r.status == tds_pkg::ST_ALL_DONE)
					n_all++;
				else
					n_wait++;
			end else begin
				idx = pk % run_len;
				id = run_list[idx];
				for (int i = idx; i + 1 < run_len; i++)
					run_list[i] = run_list[i + 1];
				run_len--;
				r.granted_id = 4'(id);
				if (done_mask[id])
					r.status = tds_pkg::ST_DONE;
				else if (!can_run(id)) begin
					run_list[run_len] = 4'(id);
					run_len++;
					r.status = tds_pkg::ST_REQUEUED;
				end else begin
					done_mask[id] = 1'b1;
					r.status = tds_pkg::ST_GRANTED;
					n_grant++;
				end
			end
			r.ready_length = 5'(run_len);
			pending = {pending, r};
		endfunction

		function void check_rsp(sched_rsp_t got);
			sched_rsp_t want;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected response %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: response %0d expected %p got %p", checked, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tds_req_if req ();
	tds_rsp_if rsp ();

	task_dependency_scheduler_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	sched_scoreboard sb;
	int cycles;
	int src_idle_pct;
	int dst_idle_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// accepted items and responses, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			sb.note_item(req.action, req.task_id, req.set_count, req.dep_set_0,
				req.dep_set_1, req.dep_set_2, req.dep_set_3, req.pick);
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_rsp(sched_rsp_t'{rsp.status, rsp.granted_id, rsp.ready_length});
	end

	// receiver stalls
	always @(negedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// valid stays up after the handshake until the next item or idle cycle
	task automatic send_item(logic act, logic [3:0] tid, logic [2:0] cnt,
			logic [15:0] d0, logic [15:0] d1, logic [15:0] d2, logic [15:0] d3,
			logic [15:0] pk);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid     <= 1'b1;
		req.action    <= act;
		req.task_id   <= tid;
		req.set_count <= cnt;
		req.dep_set_0 <= d0;
		req.dep_set_1 <= d1;
		req.dep_set_2 <= d2;
		req.dep_set_3 <= d3;
		req.pick      <= pk;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
	endtask

	// dependencies mostly on lower ids so most tasks become eligible
	function automatic logic [15:0] rand_deps(int tid);
		int k;
		k = $urandom_range(9);
		if (k == 0)
			return 16'($urandom());
		if (k < 3)
			return 16'h0;
		if (tid == 0)
			return 16'h0;
		return 16'($urandom() & ((16'h1 << tid) - 1) & $urandom());
	endfunction

	task automatic rand_add();
		logic [3:0] tid;
		tid = 4'($urandom_range(15));
		send_item(tds_pkg::ACT_ADD, tid, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
			3'($urandom_range(1, 4)), rand_deps(tid), rand_deps(tid), rand_deps(tid),
			rand_deps(tid), 16'($urandom()));
	endtask

	task automatic rand_next();
		send_item(tds_pkg::ACT_NEXT, 4'($urandom()), 3'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (40)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		sb.clear();
		cycles        = 0;
		src_idle_pct  = 0;
		dst_idle_pct  = 0;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.action    = tds_pkg::ACT_ADD;
		req.task_id   = '0;
		req.set_count = '0;
		req.dep_set_0 = '0;
		req.dep_set_1 = '0;
		req.dep_set_2 = '0;
		req.dep_set_3 = '0;
		req.pick      = '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, zero sets, oversize count, empty and high-bit sets
		send_item(tds_pkg::ACT_NEXT, 4'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
		send_item(tds_pkg::ACT_ADD, 4'd0, 3'd1, 16'h0, 16'hffff, 16'hffff, 16'hffff, 16'h0);
		send_item(tds_pkg::ACT_ADD, 4'd15, 3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h0001,
			16'h0);
		send_item(tds_pkg::ACT_ADD, 4'd5, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(tds_pkg::ACT_ADD, 4'd7, 3'd2, 16'hffff, 16'h0080, 16'h0, 16'h0, 16'h0);
		send_item(tds_pkg::ACT_NEXT, 4'hf, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'd1);
		send_item(tds_pkg::ACT_NEXT, 4'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd0);
		send_item(tds_pkg::ACT_NEXT, 4'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hfffe);
		send_item(tds_pkg::ACT_ADD, 4'd0, 3'd4, 16'h1, 16'h2, 16'h4, 16'h8, 16'h0);
		for (int i = 0; i < 8; i++)
			send_item(tds_pkg::ACT_NEXT, 4'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0,
				16'($urandom()));
		// fill past capacity to reach the full response
		for (int i = 0; i < 18; i++)
			send_item(tds_pkg::ACT_ADD, i[3:0], 3'd1, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 48 : 0;
			dst_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 36 : 0;
			for (int n = 0; n < 170; n++) begin
				if ($urandom_range(99) < 45 - ((sb.run_len > 10) ? 20 : 0))
					rand_add();
				else
					rand_next();
			end
		end
		drain();

		$display("Checked %0d responses: %0d grants, %0d list-full, %0d waiting, %0d all-done",
			sb.checked, sb.n_grant, sb.n_full, sb.n_wait, sb.n_all);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else begin
			$display("%0d mismatches, %0d responses missing", sb.errors, sb.pending.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
